### hdl/mtq_pkg.sv
`default_nettype none

package mtq_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int WORD_WIDTH  = 32;
    localparam int IO_WIDTH    = 32;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic signed [IO_WIDTH-1:0]   io_word_t;
    typedef logic [ADDR_W-1:0]            addr_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    localparam cnt_t CNT_FULL = CNT_W'(STACK_DEPTH);

    // Word range held in a wide signed carrier for saturation.
    localparam logic signed [64:0] WORD_MAX = (65'sd1 <<< (WORD_WIDTH - 1)) - 65'sd1;
    localparam logic signed [64:0] WORD_MIN = -(65'sd1 <<< (WORD_WIDTH - 1));

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic push;
        logic set_full;
        logic set_empty;
        logic xfer_start;
        logic xfer_step;
        logic xfer_end;
        logic pop_issue;
        logic pop_value;
        logic pop_top;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode_deq;
        logic in_full;
        logic in_empty;
        logic out_empty;
        logic xfer_done;
        logic out_free;
    } status_t;

    // A 32-bit port word brought into the word range, saturating if needed.
    function automatic word_t word_from_io(io_word_t x);
        logic signed [64:0] xe;
        logic signed [64:0] r;
        xe = 65'(x);
        if (xe > WORD_MAX) begin
            r = WORD_MAX;
        end else if (xe < WORD_MIN) begin
            r = WORD_MIN;
        end else begin
            r = xe;
        end
        return r[WORD_WIDTH-1:0];
    endfunction

    // A word sign-extended and cut to the 32-bit port width.
    function automatic io_word_t io_from_word(word_t w);
        logic signed [64:0] e;
        e = 65'(w);
        return e[IO_WIDTH-1:0];
    endfunction

    function automatic word_t word_max(word_t a, word_t b);
        return (a >= b) ? a : b;
    endfunction

    localparam word_t FLOOR_RESET = word_from_io(-32'sd1000);

endpackage

`default_nettype wire

### hdl/mtq_ram.sv
`default_nettype none

module mtq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/mtq_ctrl.sv
`default_nettype none

module mtq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire mtq_pkg::status_t st,
    output mtq_pkg::cmd_t        cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EXEC   = 7'b0000010,
        ST_XFER   = 7'b0000100,
        ST_POPVAL = 7'b0001000,
        ST_POPMAX = 7'b0010000,
        ST_FINISH = 7'b0100000,
        ST_SPARE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                priority if (!st.mode_deq)
                begin
                    if (st.in_full)
                    begin
                        cmd.set_full = 1'b1;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                    state_next = ST_FINISH;
                end
                else if (!st.out_empty)
                begin
                    cmd.pop_issue = 1'b1;
                    state_next    = ST_POPVAL;
                end
                else if (st.in_empty)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.xfer_start = 1'b1;
                    state_next     = ST_XFER;
                end
            end
            ST_XFER:
            begin
                // The inbound stack has been moved once the last read has been written.
                if (st.xfer_done)
                begin
                    cmd.xfer_end  = 1'b1;
                    cmd.pop_issue = 1'b1;
                    state_next    = ST_POPVAL;
                end
                else
                begin
                    cmd.xfer_step = 1'b1;
                end
            end
            ST_POPVAL:
            begin
                cmd.pop_value = 1'b1;
                state_next    = ST_POPMAX;
            end
            ST_POPMAX:
            begin
                cmd.pop_top = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hdl/mtq_datapath.sv
`default_nettype none

module mtq_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mtq_pkg::cmd_t    cmd,
    output mtq_pkg::status_t      st,
    input  wire logic             mode,
    input  wire logic signed [31:0] value,
    input  wire logic             cfg_we,
    input  wire logic signed [31:0] cfg_wdata,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic signed [31:0]    dequeued_value,
    output logic signed [31:0]    current_max,
    output logic                  empty_error,
    output logic                  full_error
);

    // Architectural state.
    mtq_pkg::cnt_t  in_cnt_reg,  in_cnt_next;
    mtq_pkg::cnt_t  out_cnt_reg, out_cnt_next;
    mtq_pkg::word_t floor_reg,   floor_next;
    mtq_pkg::word_t in_max_reg,  in_max_next;
    logic           pend_reg,    pend_next;
    logic           out_valid_reg, out_valid_next;

    // Working registers.
    logic           mode_reg;
    mtq_pkg::word_t word_reg;
    mtq_pkg::word_t run_reg;
    mtq_pkg::word_t top_max_reg;
    mtq_pkg::word_t deq_reg;
    logic           empty_flag_reg;
    logic           full_flag_reg;

    // Result register.
    logic signed [31:0] res_deq_reg;
    logic signed [31:0] res_max_reg;
    logic               res_empty_reg;
    logic               res_full_reg;

    // Stack memories.
    logic                                in_we;
    mtq_pkg::word_t                      in_rdata_w;
    logic [mtq_pkg::WORD_WIDTH-1:0]      in_rdata;
    logic                                out_we;
    logic [2*mtq_pkg::WORD_WIDTH-1:0]    out_wdata;
    logic [2*mtq_pkg::WORD_WIDTH-1:0]    out_rdata;
    mtq_pkg::addr_t                      in_raddr;
    mtq_pkg::addr_t                      out_raddr;
    mtq_pkg::word_t                      run_new;
    mtq_pkg::word_t                      base_max;
    mtq_pkg::word_t                      report_max;
    logic                                out_free;

    assign in_raddr   = mtq_pkg::ADDR_W'(in_cnt_reg - mtq_pkg::CNT_W'(1));
    assign out_raddr  = mtq_pkg::ADDR_W'(out_cnt_reg - mtq_pkg::CNT_W'(1));
    assign in_rdata_w = signed'(in_rdata);
    assign run_new    = mtq_pkg::word_max(run_reg, in_rdata_w);
    assign in_we      = cmd.push;
    assign out_we     = cmd.xfer_step && pend_reg;
    assign out_wdata  = {in_rdata_w, run_new};

    mtq_ram #(
        .WIDTH (mtq_pkg::WORD_WIDTH),
        .DEPTH (mtq_pkg::STACK_DEPTH)
    ) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_cnt_reg[mtq_pkg::ADDR_W-1:0]),
        .wdata (word_reg),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    // Each outbound entry holds the word above its running maximum.
    mtq_ram #(
        .WIDTH (2 * mtq_pkg::WORD_WIDTH),
        .DEPTH (mtq_pkg::STACK_DEPTH)
    ) u_out_ram (
        .clk   (clk),
        .we    (out_we),
        .waddr (out_cnt_reg[mtq_pkg::ADDR_W-1:0]),
        .wdata (out_wdata),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    assign base_max   = mtq_pkg::word_max(floor_reg, in_max_reg);
    assign report_max = (out_cnt_reg != '0) ? mtq_pkg::word_max(base_max, top_max_reg)
                                            : base_max;
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        st.mode_deq  = mode_reg;
        st.in_full   = (in_cnt_reg == mtq_pkg::CNT_FULL);
        st.in_empty  = (in_cnt_reg == '0);
        st.out_empty = (out_cnt_reg == '0);
        st.xfer_done = (in_cnt_reg == '0) && !pend_reg;
        st.out_free  = out_free;
    end

    always_comb
    begin
        in_cnt_next    = in_cnt_reg;
        out_cnt_next   = out_cnt_reg;
        floor_next     = floor_reg;
        in_max_next    = in_max_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end

        if (cfg_we)
        begin
            floor_next = mtq_pkg::word_from_io(cfg_wdata);
            if (in_cnt_reg == '0)
            begin
                in_max_next = mtq_pkg::word_from_io(cfg_wdata);
            end
        end

        if (cmd.push)
        begin
            in_cnt_next = in_cnt_reg + mtq_pkg::CNT_W'(1);
            in_max_next = mtq_pkg::word_max(in_max_reg, word_reg);
        end
        if (cmd.set_empty || cmd.xfer_end)
        begin
            in_max_next = floor_reg;
        end
        if (cmd.xfer_start)
        begin
            pend_next = 1'b0;
        end
        if (cmd.xfer_step)
        begin
            // The read issued this cycle returns next cycle.
            if (in_cnt_reg != '0)
            begin
                in_cnt_next = in_cnt_reg - mtq_pkg::CNT_W'(1);
                pend_next   = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
            if (pend_reg)
            begin
                out_cnt_next = out_cnt_reg + mtq_pkg::CNT_W'(1);
            end
        end
        if (cmd.pop_issue)
        begin
            out_cnt_next = out_cnt_reg - mtq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            floor_reg     <= mtq_pkg::FLOOR_RESET;
            in_max_reg    <= mtq_pkg::FLOOR_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            floor_reg     <= floor_next;
            in_max_reg    <= in_max_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mode_reg       <= mode;
            word_reg       <= mtq_pkg::word_from_io(value);
            deq_reg        <= '0;
            empty_flag_reg <= 1'b0;
            full_flag_reg  <= 1'b0;
        end
        if (cmd.set_full)
        begin
            full_flag_reg <= 1'b1;
        end
        if (cmd.set_empty)
        begin
            empty_flag_reg <= 1'b1;
        end
        if (cmd.xfer_start)
        begin
            run_reg <= floor_reg;
        end
        if (cmd.xfer_step && pend_reg)
        begin
            run_reg     <= run_new;
            top_max_reg <= run_new;
        end
        if (cmd.pop_value)
        begin
            deq_reg <= signed'(out_rdata[2*mtq_pkg::WORD_WIDTH-1:mtq_pkg::WORD_WIDTH]);
        end
        if (cmd.pop_top)
        begin
            top_max_reg <= signed'(out_rdata[mtq_pkg::WORD_WIDTH-1:0]);
        end
        if (cmd.finish)
        begin
            res_deq_reg   <= mtq_pkg::io_from_word(deq_reg);
            res_max_reg   <= mtq_pkg::io_from_word(report_max);
            res_empty_reg <= empty_flag_reg;
            res_full_reg  <= full_flag_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign dequeued_value = res_deq_reg;
    assign current_max    = res_max_reg;
    assign empty_error    = res_empty_reg;
    assign full_error     = res_full_reg;

endmodule

`default_nettype wire

### hdl/max_tracking_queue.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  mode, value
// result    out        out_valid/out_stall  dequeued_value, current_max,
//                                           empty_error, full_error
// config    in         cfg_we               cfg_wdata (max_floor)
//
// One item is worked at a time; the next transfer is taken when the controller is idle.
// A dequeue that finds the outbound stack empty first moves the n inbound words across,
// one word per cycle through the stack RAMs.
// Reset clears both counts and sets the floor and inbound maximum to -1000.
// A finished result waits in the output register while out_stall is high.

module max_tracking_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               mode,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      dequeued_value,
    output logic signed [31:0]      current_max,
    output logic                    empty_error,
    output logic                    full_error,
    input  wire logic               cfg_we,
    input  wire logic signed [31:0] cfg_wdata
);

    mtq_pkg::cmd_t    cmd;
    mtq_pkg::status_t st;

    mtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    mtq_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .mode           (mode),
        .value          (value),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dequeued_value (dequeued_value),
        .current_max    (current_max),
        .empty_error    (empty_error),
        .full_error     (full_error)
    );

endmodule

`default_nettype wire
